>>> rtl/unique_ordered_list_macros.svh
// assertion macros for the unique ordered list
// used by the top level, expects clk_i and rst_ni in scope
`ifndef UNIQUE_ORDERED_LIST_MACROS_SVH
`define UNIQUE_ORDERED_LIST_MACROS_SVH

// expression holds at every clock edge out of reset
`define UOL_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");

// antecedent implies consequent at the next edge
`define UOL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/uol_pkg.sv
// shared types and codes for the unique ordered list
// no dependencies
package uol_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_EXISTS = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } fsm_e;

  typedef struct packed {
    logic cmp;
    logic load;
    logic shift;
  } cell_ctrl_t;

  localparam int unsigned DataW = 32;

endpackage

>>> rtl/uol_cell.sv
// one storage cell of the list: holds an entry and its compare flag
// depends on uol_pkg
module uol_cell (
  input  logic                                clk_i,
  input  uol_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [uol_pkg::DataW-1:0]    key_i,
  input  logic signed [uol_pkg::DataW-1:0]    nbr_i,
  output logic signed [uol_pkg::DataW-1:0]    value_o,
  output logic                                match_o
);
  import uol_pkg::*;

  logic signed [DataW-1:0] value_d, value_q;
  logic                    match_d, match_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.load) begin
      value_d = key_i;
    end else if (ctrl_i.shift) begin
      value_d = nbr_i;
    end
    match_d = ctrl_i.cmp ? (value_q == key_i) : match_q;
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    match_q <= match_d;
  end

  assign value_o = value_q;
  assign match_o = match_q;

endmodule

>>> rtl/unique_ordered_list.sv
// unique ordered list top level: command sequencer over a chain of cells
// depends on uol_pkg, uol_cell and unique_ordered_list_macros.svh
//
// usage
//   input channel (in_valid_i / in_ready_o) carries one command beat:
//   cmd_i, value_i, position_i. output channel (out_valid_o / out_ready_i)
//   returns exactly one result beat per command: status_o, found_o,
//   read_data_o, count_o.
//   the cells first register their compare against the key in S_CMP,
//   then in S_EXEC the sequencer applies the append, the shift that
//   closes a gap, or the indexed read; in_ready_o is high only in
//   S_IDLE, so the next command waits until this one leaves S_EXEC.
//   a new command is taken while a result still waits in the output
//   register; it stops before its update until that result is taken, so a
//   stalled receiver holds the list contents and the count unchanged.
//   reset clears the entry count, the sequencer and the output valid;
//   entry storage is not reset and is only read below the count.
module unique_ordered_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        cmd_i,
  input  logic signed [uol_pkg::DataW-1:0]  value_i,
  input  logic [7:0]                        position_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        status_o,
  output logic                              found_o,
  output logic signed [uol_pkg::DataW-1:0]  read_data_o,
  output logic [4:0]                        count_o
);
  import uol_pkg::*;

  `include "unique_ordered_list_macros.svh"

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CntW > 8) ? CntW : 8;

  fsm_e state_d, state_q;

  cmd_e                    cmd_q;
  logic signed [DataW-1:0] key_q;
  logic [7:0]              pos_q;
  logic [CntW-1:0]         cnt_d, cnt_q;

  logic                    out_valid_d, out_valid_q;
  status_e                 status_d, status_q;
  logic                    found_d, found_q;
  logic signed [DataW-1:0] rd_d, rd_q;
  logic [4:0]              count_q;
  logic [CntW+4:0]         cnt_wide;

  cell_ctrl_t              ctrl    [CAPACITY];
  logic signed [DataW-1:0] cell_val[CAPACITY];
  logic signed [DataW-1:0] cell_nbr[CAPACITY];
  logic [CAPACITY-1:0]     match_raw, match_vld, pre_hit;

  logic            go, any_hit, add_ok, rem_ok;
  logic [IdxW-1:0] pos_ext, cnt_ext, rd_idx;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_last
      assign cell_nbr[i] = '0;
    end else begin : g_mid
      assign cell_nbr[i] = cell_val[i+1];
    end

    assign match_vld[i] = match_raw[i] & (cnt_q > CntW'(i));

    if (i == 0) begin : g_first
      assign pre_hit[i] = match_vld[i];
    end else begin : g_rest
      assign pre_hit[i] = pre_hit[i-1] | match_vld[i];
    end

    always_comb begin
      ctrl[i].cmp   = (state_q == S_CMP);
      ctrl[i].load  = go & add_ok & (cnt_q == CntW'(i));
      ctrl[i].shift = go & rem_ok & pre_hit[i] & (cnt_q > CntW'(i + 1));
    end

    uol_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[i]),
      .key_i   (key_q),
      .nbr_i   (cell_nbr[i]),
      .value_o (cell_val[i]),
      .match_o (match_raw[i])
    );
  end

  assign any_hit = |match_vld;
  assign go      = (state_q == S_EXEC) & (~out_valid_q | out_ready_i);
  assign add_ok  = (cmd_q == CMD_ADD) & ~any_hit & (cnt_q != CntW'(CAPACITY));
  assign rem_ok  = (cmd_q == CMD_REMOVE) & any_hit;

  assign pos_ext = IdxW'(pos_q);
  assign cnt_ext = IdxW'(cnt_q);
  assign rd_idx  = (pos_ext >= cnt_ext) ? (cnt_ext - IdxW'(1)) : pos_ext;

  always_comb begin
    status_d = ST_OK;
    found_d  = 1'b0;
    rd_d     = '0;
    cnt_d    = cnt_q;
    unique case (cmd_q)
      CMD_ADD: begin
        if (any_hit) begin
          status_d = ST_DUP;
        end else if (cnt_q == CntW'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      CMD_REMOVE: begin
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else if (!any_hit) begin
          status_d = ST_NOTFOUND;
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      CMD_EXISTS: begin
        found_d = any_hit;
      end
      CMD_READ: begin
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          for (int unsigned i = 0; i < CAPACITY; i++) begin
            rd_d = rd_d | ((rd_idx == IdxW'(i)) ? cell_val[i] : '0);
          end
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  assign cnt_wide = {5'd0, cnt_d};

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (go) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_e'(cmd_i);
      key_q <= value_i;
      pos_q <= position_i;
    end
    if (go) begin
      status_q <= status_d;
      found_q  <= found_d;
      rd_q     <= rd_d;
      count_q  <= cnt_wide[4:0];
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign read_data_o = rd_q;
  assign count_o     = count_q;

  `UOL_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CntW'(CAPACITY))
  `UOL_ASSERT_ALWAYS(a_single_hit, (state_q != S_EXEC) || $onehot0(match_vld))
  `UOL_ASSERT_NEXT(a_cnt_only_exec, !go, cnt_q == $past(cnt_q))
  `UOL_ASSERT_NEXT(a_go_gives_result, go, out_valid_q && (state_q == S_IDLE))

endmodule
